FILE: hw/rtl/early_abandon_l2_sqr_core_defines.svh
// ----------------------------------------------------------------------------
// Early-abandon squared distance: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef EARLY_ABANDON_L2_SQR_CORE_DEFINES_SVH
`define EARLY_ABANDON_L2_SQR_CORE_DEFINES_SVH

// Same-cycle implication.
`define EALS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("eals assertion failed");

// Next-cycle implication.
`define EALS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("eals assertion failed");

`endif

FILE: hw/rtl/eals_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Early-abandon squared distance: package
// Types and fixed constants shared by the front, queue, back and top level.
// ----------------------------------------------------------------------------
package eals_pkg;

	localparam int ELEM_W      = 16;
	localparam int DIFF_W      = 17;
	localparam int SQ_W        = 34;
	localparam int SUM_W       = 47;
	localparam int THR_W       = 48;
	localparam int DIM_W       = 13;
	localparam int CFG_W       = 48;
	localparam int BLOCK_LEN   = 8;
	localparam int BLOCK_BITS  = 3;
	localparam int MAX_DIM     = 4096;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_PTR_W  = 2;
	localparam int FIFO_CNT_W  = 3;

	localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(8);

	typedef enum logic {
		CFG_DIM    = 1'b0,
		CFG_THRESH = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic signed [ELEM_W-1:0] elem_a;
		logic signed [ELEM_W-1:0] elem_b;
	} pair_t;

	typedef struct packed {
		logic [SUM_W-1:0] distance;
		logic             pruned;
	} dist_t;

	// Classified work item handed from the front to the back.
	typedef struct packed {
		logic [SQ_W-1:0] square;
		logic            is_last;
		logic            do_check;
	} work_t;

endpackage

FILE: hw/rtl/eals_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Early-abandon squared distance: front end
// Accepts element pairs, squares the difference and marks the position of
// each pair within its vector (last pair, threshold check point).
// ----------------------------------------------------------------------------
module eals_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [eals_pkg::DIM_W-1:0]         dim_in_use,
	input  logic                               pair_valid,
	output logic                               pair_stall,
	input  eals_pkg::pair_t                    pair,
	input  logic [eals_pkg::FIFO_CNT_W-1:0]    fifo_count,
	output logic                               work_valid_s1,
	output eals_pkg::work_t                    work_s1
);
	import eals_pkg::*;

	logic [DIM_W-1:0]         eff_dim;
	logic [BLOCK_BITS-1:0]    tail;
	logic                     has_block;
	logic [DIM_W-1:0]         pos_q;
	logic [DIM_W-1:0]         pos_off;
	logic                     is_last;
	logic                     do_check;
	logic signed [DIFF_W-1:0] diff;
	logic signed [SQ_W-1:0]   prod;
	logic                     accept;

	always_comb begin
		eff_dim = dim_in_use;
		if (dim_in_use == '0) begin
			eff_dim = DIM_W'(1);
		end else if (32'(dim_in_use) > MAX_DIM) begin
			eff_dim = DIM_W'(MAX_DIM);
		end
		tail      = eff_dim[BLOCK_BITS-1:0];
		has_block = eff_dim >= DIM_W'(BLOCK_LEN);
		is_last   = pos_q >= (eff_dim - DIM_W'(1));
		pos_off   = pos_q - DIM_W'(tail);
		// A check point is the first pair of every full block after the tail.
		do_check  = has_block && (pos_q >= DIM_W'(tail)) && (pos_q < eff_dim) &&
			(pos_off[BLOCK_BITS-1:0] == '0);
		diff = {pair.elem_a[ELEM_W-1], pair.elem_a} - {pair.elem_b[ELEM_W-1], pair.elem_b};
		prod = diff * diff;
	end

	// One slot is held back for the item sitting in the stage register.
	assign pair_stall = (32'(fifo_count) + 32'(work_valid_s1)) >= FIFO_DEPTH;
	assign accept     = pair_valid && !pair_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q         <= '0;
			work_valid_s1 <= 1'b0;
		end else begin
			work_valid_s1 <= accept;
			if (accept) begin
				pos_q <= is_last ? '0 : pos_q + DIM_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			work_s1.square   <= SQ_W'(unsigned'(prod));
			work_s1.is_last  <= is_last;
			work_s1.do_check <= do_check;
		end
	end

endmodule

FILE: hw/rtl/eals_fifo.sv
`timescale 1ns / 1ps
`include "early_abandon_l2_sqr_core_defines.svh"
// ----------------------------------------------------------------------------
// Early-abandon squared distance: work queue
// Short queue of classified work items between the front and the back.
// ----------------------------------------------------------------------------
module eals_fifo (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               push,
	input  eals_pkg::work_t                    push_data,
	input  logic                               pop,
	output eals_pkg::work_t                    pop_data,
	output logic                               not_empty,
	output logic [eals_pkg::FIFO_CNT_W-1:0]    count
);
	import eals_pkg::*;

	work_t                 entry_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;

	assign count     = count_q;
	assign not_empty = count_q != '0;
	assign pop_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + FIFO_CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - FIFO_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	`EALS_ASSERT_IMP(a_fifo_no_overflow, push && !pop, 32'(count_q) < FIFO_DEPTH)
	`EALS_ASSERT_IMP(a_fifo_no_underflow, pop, count_q != '0)

endmodule

FILE: hw/rtl/eals_back.sv
`timescale 1ns / 1ps
`include "early_abandon_l2_sqr_core_defines.svh"
// ----------------------------------------------------------------------------
// Early-abandon squared distance: back end
// Accumulates squares, applies the threshold at check points, drops the rest
// of a pruned vector and holds the result in an output register.
// ----------------------------------------------------------------------------
module eals_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic signed [eals_pkg::THR_W-1:0]  prune_threshold,
	input  logic                               work_valid,
	input  eals_pkg::work_t                    work,
	output logic                               work_pop,
	output logic                               dist_valid,
	input  logic                               dist_stall,
	output eals_pkg::dist_t                    dist_data
);
	import eals_pkg::*;

	logic [SUM_W-1:0] sum_q;
	logic             disc_q;
	logic [THR_W-1:0] sum_ext;
	logic [SUM_W-1:0] sum_sat;
	logic             over;
	logic             prune;
	logic             emit_full;

	always_comb begin
		sum_ext   = {1'b0, sum_q} + THR_W'(work.square);
		sum_sat   = sum_ext[THR_W-1] ? '1 : sum_ext[SUM_W-1:0];
		over      = $signed({1'b0, sum_q}) > prune_threshold;
		prune     = !disc_q && work.do_check && over;
		emit_full = !disc_q && !prune && work.is_last;
	end

	// The output register frees up in the same cycle it is taken.
	assign work_pop = work_valid && (!dist_valid || !dist_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q      <= '0;
			disc_q     <= 1'b0;
			dist_valid <= 1'b0;
		end else begin
			if (dist_valid && !dist_stall) begin
				dist_valid <= 1'b0;
			end
			if (work_pop) begin
				if (prune || emit_full) begin
					dist_valid <= 1'b1;
				end
				if (work.is_last) begin
					sum_q  <= '0;
					disc_q <= 1'b0;
				end else if (prune) begin
					disc_q <= 1'b1;
				end else if (!disc_q) begin
					sum_q <= sum_sat;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (work_pop && prune) begin
			dist_data.distance <= sum_q;
			dist_data.pruned   <= 1'b1;
		end else if (work_pop && emit_full) begin
			dist_data.distance <= sum_sat;
			dist_data.pruned   <= 1'b0;
		end
	end

	`EALS_ASSERT_NEXT(a_back_vector_clear, work_pop && work.is_last, (sum_q == '0) && !disc_q)
	`EALS_ASSERT_IMP(a_back_slot_free, work_pop, !(dist_valid && dist_stall))

endmodule

FILE: hw/rtl/early_abandon_l2_sqr_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Early-abandon squared distance core
// Sums squared element differences of two vectors and ends a vector early
// when the running sum passes the threshold at a block boundary.
//
// Channel   Handshake                 Payload
// pair      pair_valid / pair_stall   elem_a, elem_b
// dist      dist_valid / dist_stall   distance, pruned
// cfg       cfg_we                    cfg_index, cfg_data
//
// One pair is taken per cycle unless stalled; a result passes the front stage
// register, the queue and the output register. The front multiplier stage
// and the back accumulator, joined by a four-entry queue, each handle one
// pair per cycle unless stalled. Reset clears the queue, the vector position,
// the running sum and the output register; dim_in_use returns to 8 and
// prune_threshold to 0. A stall on dist fills the queue and then stalls pair.
// ----------------------------------------------------------------------------
module early_abandon_l2_sqr_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  eals_pkg::cfg_idx_t            cfg_index,
	input  logic [eals_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          pair_valid,
	output logic                          pair_stall,
	input  eals_pkg::pair_t               pair,
	output logic                          dist_valid,
	input  logic                          dist_stall,
	output eals_pkg::dist_t               dist_data
);
	import eals_pkg::*;

	logic [DIM_W-1:0]        dim_q;
	logic signed [THR_W-1:0] thr_q;
	logic                    work_valid_s1;
	work_t                   work_s1;
	work_t                   head;
	logic                    head_valid;
	logic                    head_pop;
	logic [FIFO_CNT_W-1:0]   fifo_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q <= DIM_RESET;
			thr_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DIM:    dim_q <= cfg_data[DIM_W-1:0];
				CFG_THRESH: thr_q <= cfg_data[THR_W-1:0];
				default:    ;
			endcase
		end
	end

	eals_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.dim_in_use    (dim_q),
		.pair_valid    (pair_valid),
		.pair_stall    (pair_stall),
		.pair          (pair),
		.fifo_count    (fifo_count),
		.work_valid_s1 (work_valid_s1),
		.work_s1       (work_s1)
	);

	eals_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (work_valid_s1),
		.push_data (work_s1),
		.pop       (head_pop),
		.pop_data  (head),
		.not_empty (head_valid),
		.count     (fifo_count)
	);

	eals_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.prune_threshold (thr_q),
		.work_valid      (head_valid),
		.work            (head),
		.work_pop        (head_pop),
		.dist_valid      (dist_valid),
		.dist_stall      (dist_stall),
		.dist_data       (dist_data)
	);

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the early-abandon squared distance core
// Streams element pairs through the core under random sender bursts and
// receiver stalls. A behavioral copy of the core predicts each distance and
// pruned flag, and every result transfer is checked against the oldest
// prediction. A short directed table covers the extremes and corner cases.
// After that come a probe of the saturated dimension, a long run at the
// largest dimension, and random phases with changing dimension and threshold.
// ----------------------------------------------------------------------------
module tb_top;
	import eals_pkg::*;

	localparam int          HALF_PERIOD = 6;
	localparam int          RAND_ITEMS  = 1500;
	localparam int          LIMIT_PAIRS = 400;
	localparam int          SETTLE_CYC  = 12;
	localparam int          TAIL_CYC    = 20;
	localparam longint      CYCLE_LIMIT = 1000000;
	localparam int          MAX_PRINTS  = 50;
	localparam logic [47:0] DIST_CEIL   = (48'd1 << SUM_W) - 48'd1;
	localparam logic [47:0] THR_MAX     = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] THR_MIN     = 48'h8000_0000_0000;
	localparam logic [47:0] THR_NEG1    = 48'hFFFF_FFFF_FFFF;
	localparam logic [15:0] E_MIN       = 16'h8000;
	localparam logic [15:0] E_MAX       = 16'h7FFF;

	typedef enum logic {R_CFG, R_PAIR} row_kind_t;
	// How a pair row is checked: by the predictor, as causing no result,
	// or against the result typed into the row.
	typedef enum logic [1:0] {C_MODEL, C_NONE, C_GIVEN} chk_t;

	typedef struct packed {
		row_kind_t          kind;
		cfg_idx_t           reg_sel;
		logic [47:0]        data;
		logic signed [15:0] a;
		logic signed [15:0] b;
		chk_t               chk;
		logic [46:0]        exp_dist;
		logic               pruned;
	} row_t;

	localparam int DIR_ROWS = 25;
	localparam row_t DIR_TABLE [DIR_ROWS] = '{
		'{R_CFG,  CFG_DIM,    48'd0,    16'd0, 16'd0,     C_MODEL, 47'd0,           1'b0},
		'{R_PAIR, CFG_DIM,    48'd0,    E_MIN, E_MAX,     C_GIVEN, 47'd4294836225,  1'b0},
		'{R_PAIR, CFG_DIM,    48'd0,    E_MAX, E_MIN,     C_GIVEN, 47'd4294836225,  1'b0},
		'{R_PAIR, CFG_DIM,    48'd0,    16'd0, 16'd0,     C_GIVEN, 47'd0,           1'b0},
		'{R_CFG,  CFG_THRESH, THR_NEG1, 16'd0, 16'd0,     C_MODEL, 47'd0,           1'b0},
		'{R_CFG,  CFG_DIM,    48'd8,    16'd0, 16'd0,     C_MODEL, 47'd0,           1'b0},
		'{R_PAIR, CFG_DIM,    48'd0,    16'd5, 16'hFFFB,  C_GIVEN, 47'd0,           1'b1},
		'{R_CFG,  CFG_DIM,    48'd1,    16'd0, 16'd0,     C_MODEL, 47'd0,           1'b0},
		'{R_PAIR, CFG_DIM,    48'd0,    16'd100, 16'd0,   C_NONE,  47'd0,           1'b0},
		'{R_PAIR, CFG_DIM,    48'd0,    16'd3, 16'd1,     C_GIVEN, 47'd4,           1'b0},
		'{R_CFG,  CFG_THRESH, 48'd0,    16'd0, 16'd0,     C_MODEL, 47'd0,           1'b0},
		'{R_CFG,  CFG_DIM,    48'd9,    16'd0, 16'd0,     C_MODEL, 47'd0,           1'b0},
		'{R_PAIR, CFG_DIM,    48'd0,    16'd1, 16'd0,     C_NONE,  47'd0,           1'b0},
		'{R_PAIR, CFG_DIM,    48'd0,    16'd7, 16'd7,     C_GIVEN, 47'd1,           1'b1},
		'{R_CFG,  CFG_DIM,    48'd2,    16'd0, 16'd0,     C_MODEL, 47'd0,           1'b0},
		'{R_PAIR, CFG_DIM,    48'd0,    16'd0, 16'd0,     C_NONE,  47'd0,           1'b0},
		'{R_CFG,  CFG_THRESH, THR_MAX,  16'd0, 16'd0,     C_MODEL, 47'd0,           1'b0},
		'{R_CFG,  CFG_DIM,    48'd3,    16'd0, 16'd0,     C_MODEL, 47'd0,           1'b0},
		'{R_PAIR, CFG_DIM,    48'd0,    E_MIN, E_MAX,     C_MODEL, 47'd0,           1'b0},
		'{R_PAIR, CFG_DIM,    48'd0,    E_MAX, E_MIN,     C_MODEL, 47'd0,           1'b0},
		'{R_PAIR, CFG_DIM,    48'd0,    E_MIN, E_MAX,     C_GIVEN, 47'd12884508675, 1'b0},
		'{R_CFG,  CFG_THRESH, THR_MIN,  16'd0, 16'd0,     C_MODEL, 47'd0,           1'b0},
		'{R_PAIR, CFG_DIM,    48'd0,    16'd0, 16'd1,     C_NONE,  47'd0,           1'b0},
		'{R_PAIR, CFG_DIM,    48'd0,    16'd0, 16'd0,     C_NONE,  47'd0,           1'b0},
		'{R_PAIR, CFG_DIM,    48'd0,    16'd2, 16'd0,     C_GIVEN, 47'd5,           1'b0}
	};

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        cfg_we     = 1'b0;
	cfg_idx_t    cfg_index  = CFG_DIM;
	logic [CFG_W-1:0] cfg_data = '0;
	logic        pair_valid = 1'b0;
	logic        pair_stall;
	pair_t       pair       = '0;
	logic        dist_valid;
	logic        dist_stall = 1'b0;
	dist_t       dist_data;

	// What the row now being driven expects; stable while its pair is held.
	chk_t        drive_chk    = C_MODEL;
	logic [46:0] drive_dist   = '0;
	logic        drive_pruned = 1'b0;

	// Predictor copy of the core's registers and vector state.
	logic [DIM_W-1:0]        dim_reg      = DIM_RESET;
	logic signed [THR_W-1:0] thresh_reg   = '0;
	logic [47:0]             sum_acc      = '0;
	logic [DIM_W-1:0]        vec_pos      = '0;
	logic                    vec_dropping = 1'b0;

	dist_t  expected_dist_q[$];
	int     err_count    = 0;
	longint cycle_cnt    = 0;
	int     burst_left   = 0;
	int     stall_mode   = 0;
	int     stall_left   = 0;
	int     pairs_taken  = 0;
	int     cfg_writes   = 0;
	int     full_results = 0;
	int     pruned_results = 0;

	early_abandon_l2_sqr_core uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pair_valid (pair_valid),
		.pair_stall (pair_stall),
		.pair       (pair),
		.dist_valid (dist_valid),
		.dist_stall (dist_stall),
		.dist_data  (dist_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding.",
				cycle_cnt, expected_dist_q.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		if (err_count < MAX_PRINTS)
			$display("MISMATCH at cycle %0d: %s", cycle_cnt, msg);
		err_count++;
	endtask

	function automatic int unsigned eff_dim(input logic [DIM_W-1:0] d);
		if (d == '0)
			return 1;
		if (d > MAX_DIM)
			return MAX_DIM;
		return d;
	endfunction

	// Takes one accepted pair into the predicted state and gives the result
	// that the pair causes, if any.
	task automatic accumulate_pair(input pair_t p, output bit emitted, output dist_t res);
		int unsigned eff;
		int unsigned tail;
		int unsigned pos;
		bit          at_end;
		bit          at_block;
		longint      diff;
		longint      thr_l;
		eff      = eff_dim(dim_reg);
		tail     = eff % BLOCK_LEN;
		pos      = vec_pos;
		at_end   = (pos + 1 >= eff);
		emitted  = 1'b0;
		res      = '0;
		if (!vec_dropping) begin
			at_block = (eff >= BLOCK_LEN) && (pos >= tail) && (pos < eff) &&
				((pos - tail) % BLOCK_LEN == 0);
			thr_l = thresh_reg;
			if (at_block && longint'(sum_acc) > thr_l) begin
				res.distance = sum_acc[SUM_W-1:0];
				res.pruned   = 1'b1;
				emitted      = 1'b1;
				vec_dropping = 1'b1;
			end else begin
				diff    = longint'(p.elem_a) - longint'(p.elem_b);
				sum_acc = sum_acc + 48'(diff * diff);
				if (sum_acc > DIST_CEIL)
					sum_acc = DIST_CEIL;
				if (at_end) begin
					res.distance = sum_acc[SUM_W-1:0];
					res.pruned   = 1'b0;
					emitted      = 1'b1;
				end
			end
		end
		if (at_end) begin
			sum_acc      = '0;
			vec_pos      = '0;
			vec_dropping = 1'b0;
		end else begin
			vec_pos = DIM_W'(pos + 1);
		end
	endtask

	always @(posedge clk) begin
		bit    emitted;
		dist_t res;
		dist_t want;
		if (arst_n) begin
			if (dist_valid && !dist_stall) begin
				if (expected_dist_q.size() == 0) begin
					report_mismatch($sformatf("result %0d/%0d with nothing expected",
						dist_data.distance, dist_data.pruned));
				end else begin
					want = expected_dist_q.pop_front();
					if (dist_data.distance !== want.distance)
						report_mismatch($sformatf("distance %0d, expected %0d",
							dist_data.distance, want.distance));
					if (dist_data.pruned !== want.pruned)
						report_mismatch($sformatf("pruned %0b, expected %0b",
							dist_data.pruned, want.pruned));
					if (want.pruned)
						pruned_results++;
					else
						full_results++;
				end
			end
			if (cfg_we) begin
				cfg_writes++;
				case (cfg_index)
					CFG_DIM:    dim_reg    = cfg_data[DIM_W-1:0];
					CFG_THRESH: thresh_reg = cfg_data[THR_W-1:0];
					default:    ;
				endcase
			end
			if (pair_valid && !pair_stall) begin
				pairs_taken++;
				accumulate_pair(pair, emitted, res);
				case (drive_chk)
					C_MODEL: begin
						if (emitted)
							expected_dist_q.push_back(res);
					end
					C_GIVEN: begin
						expected_dist_q.push_back('{distance: drive_dist,
							pruned: drive_pruned});
					end
					default: ;
				endcase
			end
		end
	end

	// The receiver switches to a new random stall pattern when its random run ends.
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(50, 300);
		end
		stall_left--;
		case (stall_mode)
			0:       dist_stall <= 1'b0;
			1:       dist_stall <= ($urandom_range(0, 99) < 30);
			2:       dist_stall <= ((cycle_cnt % 11) < 7);
			default: dist_stall <= ($urandom_range(0, 99) < 70);
		endcase
	end

	task automatic send_pair(input logic signed [15:0] a, input logic signed [15:0] b,
		input chk_t chk, input logic [46:0] d, input logic p);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				pair_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300) :
				$urandom_range(1, 24);
		end
		pair_valid   <= 1'b1;
		pair         <= '{elem_a: a, elem_b: b};
		drive_chk    <= chk;
		drive_dist   <= d;
		drive_pruned <= p;
		@(posedge clk);
		while (pair_stall)
			@(posedge clk);
		@(negedge clk);
		burst_left--;
	endtask

	task automatic wait_drained();
		pair_valid <= 1'b0;
		while (expected_dist_q.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Pairs that cause no result may still be inside the core once every
	// result has arrived, so a register write waits a little longer.
	task automatic settle();
		wait_drained();
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t sel, input logic [47:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		@(negedge clk);
	endtask

	task automatic make_pair(input int mode, output logic signed [15:0] a,
		output logic signed [15:0] b);
		case (mode)
			0: begin
				a = 16'($urandom);
				b = 16'($urandom);
			end
			1: begin
				a = 16'(int'($urandom_range(0, 32)) - 16);
				b = 16'(int'($urandom_range(0, 32)) - 16);
			end
			default: begin
				case ($urandom_range(0, 3))
					0:       a = E_MIN;
					1:       a = E_MAX;
					2:       a = 16'h0000;
					default: a = 16'hFFFF;
				endcase
				b = ($urandom_range(0, 1) == 1) ? E_MAX : E_MIN;
			end
		endcase
		if ($urandom_range(0, 9) == 0)
			b = a;
	endtask

	function automatic logic [47:0] pick_thresh(input int unsigned eff, input int mode);
		longint span;
		span = longint'(eff) * ((mode == 1) ? 64'd250 : 64'd700000000);
		case ($urandom_range(0, 19))
			0:       return THR_MAX;
			1:       return THR_MIN;
			2:       return THR_NEG1;
			3:       return 48'd0;
			4:       return 48'(-longint'($urandom_range(1, 1000000)));
			default: return 48'((span * $urandom_range(0, 150)) / 100);
		endcase
	endfunction

	initial begin
		row_t               row;
		logic signed [15:0] ea;
		logic signed [15:0] eb;
		logic [DIM_W-1:0]   new_dim;
		logic [47:0]        dim_word;
		int unsigned        eff;
		int                 mode;
		int                 count;
		int                 rand_items;
		rand_items = 0;

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			row = DIR_TABLE[i];
			if (row.kind == R_CFG) begin
				settle();
				write_reg(row.reg_sel, row.data);
			end else begin
				send_pair(row.a, row.b, row.chk, row.exp_dist, row.pruned);
			end
		end

		// Largest dimension: a register value above the limit saturates, so
		// the vector has no tail and a negative threshold prunes on the first
		// pair. A dimension of one then ends the dropped vector on the next
		// pair, and a long run at the limit crosses the threshold partway.
		settle();
		dim_word        = 48'({$urandom, $urandom});
		dim_word[12:0]  = 13'h1FFF;
		write_reg(CFG_DIM, dim_word);
		write_reg(CFG_THRESH, THR_NEG1);
		repeat (BLOCK_LEN) begin
			make_pair(2, ea, eb);
			send_pair(ea, eb, C_MODEL, '0, 1'b0);
		end
		settle();
		write_reg(CFG_DIM, 48'd1);
		make_pair(2, ea, eb);
		send_pair(ea, eb, C_NONE, '0, 1'b0);
		settle();
		write_reg(CFG_THRESH, 48'd200000000000);
		write_reg(CFG_DIM, 48'(MAX_DIM));
		repeat (LIMIT_PAIRS) begin
			make_pair(2, ea, eb);
			send_pair(ea, eb, C_MODEL, '0, 1'b0);
		end

		while (rand_items < RAND_ITEMS) begin
			settle();
			case ($urandom_range(0, 19))
				0:       new_dim = 13'd0;
				1:       new_dim = 13'd8;
				2:       new_dim = 13'd16;
				3:       new_dim = 13'd7;
				15, 16, 17, 18, 19: new_dim = 13'($urandom_range(25, 64));
				default: new_dim = 13'($urandom_range(1, 24));
			endcase
			eff  = eff_dim(new_dim);
			mode = $urandom_range(0, 2);
			dim_word       = 48'({$urandom, $urandom});
			dim_word[12:0] = new_dim;
			if ($urandom_range(0, 1) == 1) begin
				write_reg(CFG_DIM, dim_word);
				write_reg(CFG_THRESH, pick_thresh(eff, mode));
			end else begin
				write_reg(CFG_THRESH, pick_thresh(eff, mode));
				write_reg(CFG_DIM, dim_word);
			end
			// Mostly whole vectors, finishing the one left open; now and then
			// a ragged count that stops partway.
			if ($urandom_range(0, 4) == 0)
				count = $urandom_range(1, 30);
			else
				count = ((vec_pos < eff) ? eff - vec_pos : 1) + eff * $urandom_range(0, 5);
			repeat (count) begin
				make_pair(mode, ea, eb);
				send_pair(ea, eb, C_MODEL, '0, 1'b0);
				rand_items++;
				if ($urandom_range(0, 149) == 0)
					wait_drained();
			end
		end

		wait_drained();
		repeat (TAIL_CYC) @(posedge clk);
		while (expected_dist_q.size() != 0) begin
			void'(expected_dist_q.pop_front());
			report_mismatch("expected result never arrived");
		end
		$display("Sent %0d pairs (%0d random) with %0d register writes.",
			pairs_taken, rand_items, cfg_writes);
		$display("Checked %0d full distances and %0d pruned distances.",
			full_results, pruned_results);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
